FILE: src/vpa_pkg.sv
// vpa_pkg: types and constants of the variable partition allocator
// no dependencies

package vpa_pkg;

    localparam logic [1:0] POLICY_WORST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_FIRST = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADID   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
    localparam logic [1:0] CFG_MIN_SPLIT  = 2'd1;

    localparam logic [1:0]  FIT_POLICY_RESET = POLICY_FIRST;
    localparam logic [15:0] MIN_SPLIT_RESET  = 16'd16;

    // result item
    typedef struct packed {
        logic [15:0] granted_len;
        logic [15:0] granted_addr;
        logic [7:0]  granted_id;
        logic [1:0]  status;
    } result_t;

endpackage

FILE: src/variable_partition_allocator.sv
// variable_partition_allocator: top level, hole and held tables in synchronous memories
// depends on vpa_pkg
//
//  channel  | ports            | contents
//  s_axis   | s_tvalid/tready  | tuser: req_type; tdata: req_size[15:0], block_id[23:16]
//  m_axis   | m_tvalid/tready  | tuser: status; tdata: id[7:0], addr[23:8], len[39:24]
//  cfg      | cfg_we/idx/wdata | 0 fit_policy, 1 min_split
//
// One request at a time. An allocate walks the hole memory, then the held memory, and
// writes back on success; a free walks the held memory, then the hole memory if the id
// is held, and writes back on success. The result sits in an output register; s_tready
// stays low until it is taken. Reset is synchronous; hole entry 0 is loaded during
// reset and valid flip-flops mark live entries, so no clearing pass.

module variable_partition_allocator
    import vpa_pkg::*;
#(
    parameter int HOLE_SLOTS = 16,
    parameter int HELD_SLOTS = 16,
    parameter int MEM_SIZE   = 32768,
    parameter int BASE_ADDR  = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // req_type
    input  logic [23:0] s_tdata,   // req_size, block_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [39:0] m_tdata,   // granted_id, granted_addr, granted_len
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata
);

    localparam int HW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int DW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_HSCAN  = 9'b000000010,
        S_DSCAN  = 9'b000000100,
        S_AWB    = 9'b000001000,
        S_FDSCAN = 9'b000010000,
        S_FHSCAN = 9'b000100000,
        S_FWB1   = 9'b001000000,
        S_FWB2   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]  fit_reg;
    logic [15:0] split_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg   <= FIT_POLICY_RESET;
            split_reg <= MIN_SPLIT_RESET;
        end else if (cfg_we) begin
            if (cfg_idx == CFG_FIT_POLICY) fit_reg <= cfg_wdata[1:0];
            if (cfg_idx == CFG_MIN_SPLIT) split_reg <= cfg_wdata;
        end
    end

    // memories and valid bits
    logic [31:0] hole_mem [HOLE_SLOTS];   // {len, start}
    logic [39:0] held_mem [HELD_SLOTS];   // {id, len, start}
    logic [HOLE_SLOTS-1:0] hole_v_reg;
    logic [HELD_SLOTS-1:0] held_v_reg;

    logic          hwe;
    logic [HW-1:0] hwa, hra;
    logic [31:0]   hwd, hrd_reg;
    logic          dwe;
    logic [DW-1:0] dwa, dra;
    logic [39:0]   dwd, drd_reg;

    // entry 0 of the hole table is preset on reset
    logic init_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) init_reg <= 1'b1;
        else init_reg <= 1'b0;
    end
    logic [31:0] hole0;
    assign hole0 = {16'(MEM_SIZE), 16'(BASE_ADDR)};

    always_ff @(posedge aclk) begin
        if (init_reg) hole_mem[0] <= hole0;
        else if (hwe) hole_mem[hwa] <= hwd;
        hrd_reg <= hole_mem[hra];
    end
    always_ff @(posedge aclk) begin
        if (dwe) held_mem[dwa] <= dwd;
        drd_reg <= held_mem[dra];
    end

    // request and scan registers
    logic          type_reg;
    logic [15:0]   size_reg;
    logic [7:0]    id_reg;
    logic [HW:0]   hcnt_reg;   // read address counter
    logic [DW:0]   dcnt_reg;
    logic [HW-1:0] hidx_reg;   // index of data in hrd_reg
    logic [DW-1:0] didx_reg;
    logic          hrv_reg, drv_reg;
    // allocate pick
    logic          found_reg;
    logic [HW-1:0] pick_reg;
    logic [15:0]   pstart_reg, plen_reg;
    logic [8:0]    top_reg;
    logic          slot_ok_reg;
    logic [DW-1:0] slot_reg;
    // free search
    logic          hit_reg;
    logic [DW-1:0] k_reg;
    logic [15:0]   fs_reg, fl_reg;
    logic          hp_reg, hn_reg, spok_reg;
    logic [HW-1:0] prev_reg, next_reg, spare_reg;
    logic [15:0]   plen2_reg, nlen_reg;
    logic [15:0]   hpstart_reg;
    result_t       res_reg;

    logic [15:0] hs, hl, ds, dl;
    logic [7:0]  did;
    logic        hv, dv, better;
    logic [16:0] fe;

    assign hs  = hrd_reg[15:0];
    assign hl  = hrd_reg[31:16];
    assign hv  = hrv_reg & hole_v_reg[hidx_reg];
    assign ds  = drd_reg[15:0];
    assign dl  = drd_reg[31:16];
    assign did = drd_reg[39:32];
    assign dv  = drv_reg & held_v_reg[didx_reg];
    assign fe  = {1'b0, fs_reg} + {1'b0, fl_reg};

    // candidate comparison for the fit policy
    always_comb begin
        priority if (fit_reg == POLICY_WORST && hl != plen_reg) better = hl > plen_reg;
        else if (fit_reg == POLICY_BEST && hl != plen_reg) better = hl < plen_reg;
        else better = hs < pstart_reg;
    end

    logic [16:0] rem;
    assign rem = {1'b0, plen_reg} - {1'b0, size_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {res_reg.granted_len, res_reg.granted_addr, res_reg.granted_id};

    logic hdone, ddone;
    assign hdone = (hcnt_reg == (HW+1)'(HOLE_SLOTS));
    assign ddone = (dcnt_reg == (DW+1)'(HELD_SLOTS));

    // memory port control and next-state logic
    always_comb begin
        hra = hcnt_reg[HW-1:0];
        dra = dcnt_reg[DW-1:0];
        hwe = 1'b0; hwa = pick_reg; hwd = '0;
        dwe = 1'b0; dwa = slot_reg; dwd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid)
                state_next = (s_tuser == REQ_ALLOC) ? S_HSCAN : S_FDSCAN;
            S_HSCAN: if (hdone && !hrv_reg)
                state_next = S_DSCAN;
            S_DSCAN: if (ddone && !drv_reg) begin
                if (!found_reg || !slot_ok_reg || top_reg >= 9'd255) state_next = S_OUT;
                else state_next = S_AWB;
            end
            S_AWB: begin
                hwe = 1'b1;
                hwd = {rem[15:0], 16'(pstart_reg + size_reg)};
                dwe = 1'b1;
                dwd = {8'(top_reg + 9'd1),
                       (rem < {1'b0, split_reg}) ? plen_reg : size_reg, pstart_reg};
                state_next = S_OUT;
            end
            S_FDSCAN: if (ddone && !drv_reg)
                state_next = hit_reg ? S_FHSCAN : S_OUT;
            S_FHSCAN: if (hdone && !hrv_reg) begin
                if (!hp_reg && !hn_reg && !spok_reg) state_next = S_OUT;
                else state_next = S_FWB1;
            end
            S_FWB1: begin
                hwe = 1'b1;
                if (hp_reg) begin
                    hwa = prev_reg;
                    hwd = {16'(plen2_reg + fl_reg + (hn_reg ? nlen_reg : 16'd0)),
                           hpstart_reg};
                end else if (hn_reg) begin
                    hwa = next_reg;
                    hwd = {16'(nlen_reg + fl_reg), fs_reg};
                end else begin
                    hwa = spare_reg;
                    hwd = {fl_reg, fs_reg};
                end
                state_next = S_OUT;
            end
            S_FWB2: state_next = S_OUT;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            hole_v_reg <= HOLE_SLOTS'(1);
            held_v_reg <= '0;
            hrv_reg    <= 1'b0;
            drv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            hrv_reg   <= 1'b0;
            drv_reg   <= 1'b0;
            hidx_reg  <= hcnt_reg[HW-1:0];
            didx_reg  <= dcnt_reg[DW-1:0];
            unique case (state_reg)
                S_IDLE: begin
                    type_reg <= s_tuser;
                    size_reg <= s_tdata[15:0];
                    id_reg   <= s_tdata[23:16];
                    hcnt_reg <= '0; dcnt_reg <= '0;
                    found_reg <= 1'b0; slot_ok_reg <= 1'b0; top_reg <= '0;
                    hit_reg <= 1'b0; hp_reg <= 1'b0; hn_reg <= 1'b0; spok_reg <= 1'b0;
                    pick_reg <= '0; slot_reg <= '0;
                end
                S_HSCAN: begin
                    if (!hdone) begin
                        hcnt_reg <= hcnt_reg + 1'b1;
                        hrv_reg  <= 1'b1;
                    end
                    if (hv && hl > size_reg && (!found_reg || better)) begin
                        found_reg  <= 1'b1;
                        pick_reg   <= hidx_reg;
                        pstart_reg <= hs;
                        plen_reg   <= hl;
                    end
                end
                S_DSCAN, S_FDSCAN: begin
                    if (!ddone) begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        drv_reg  <= 1'b1;
                    end
                    if (drv_reg) begin
                        if (held_v_reg[didx_reg]) begin
                            if ({1'b0, did} > top_reg) top_reg <= {1'b0, did};
                        end else if (!slot_ok_reg) begin
                            slot_ok_reg <= 1'b1;
                            slot_reg    <= didx_reg;
                        end
                        if (dv && did == id_reg && id_reg != 8'd0 && !hit_reg) begin
                            hit_reg <= 1'b1;
                            k_reg   <= didx_reg;
                            fs_reg  <= ds;
                            fl_reg  <= dl;
                        end
                    end
                end
                S_AWB: begin
                    held_v_reg[slot_reg] <= 1'b1;
                    if (rem < {1'b0, split_reg}) hole_v_reg[pick_reg] <= 1'b0;
                end
                S_FHSCAN: begin
                    if (!hdone) begin
                        hcnt_reg <= hcnt_reg + 1'b1;
                        hrv_reg  <= 1'b1;
                    end
                    if (hrv_reg) begin
                        if (!hole_v_reg[hidx_reg]) begin
                            if (!spok_reg) begin
                                spok_reg <= 1'b1; spare_reg <= hidx_reg;
                            end
                        end else if (!hp_reg && 17'(hs) + 17'(hl) == 17'(fs_reg)) begin
                            hp_reg <= 1'b1; prev_reg <= hidx_reg;
                            plen2_reg <= hl; hpstart_reg <= hs;
                        end else if (!hn_reg && 17'(hs) == fe) begin
                            hn_reg <= 1'b1; next_reg <= hidx_reg; nlen_reg <= hl;
                        end
                    end
                end
                S_FWB1: begin
                    held_v_reg[k_reg] <= 1'b0;
                    if (hp_reg && hn_reg) hole_v_reg[next_reg] <= 1'b0;
                    else if (!hp_reg && !hn_reg) hole_v_reg[spare_reg] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_next == S_OUT && state_reg != S_OUT) begin
            res_reg <= '0;
            if (type_reg == REQ_ALLOC) begin
                if (!found_reg) res_reg.status <= ST_NOSPACE;
                else if (!slot_ok_reg || top_reg >= 9'd255) res_reg.status <= ST_FULL;
                else begin
                    res_reg.status       <= ST_OK;
                    res_reg.granted_id   <= 8'(top_reg + 9'd1);
                    res_reg.granted_addr <= pstart_reg;
                    res_reg.granted_len  <= (rem < {1'b0, split_reg}) ? plen_reg : size_reg;
                end
            end else begin
                if (!hit_reg) res_reg.status <= ST_BADID;
                else if (!hp_reg && !hn_reg && !spok_reg) res_reg.status <= ST_FULL;
                else begin
                    res_reg.status       <= ST_OK;
                    res_reg.granted_id   <= id_reg;
                    res_reg.granted_addr <= fs_reg;
                    res_reg.granted_len  <= fl_reg;
                end
            end
        end
    end

endmodule

FILE: src/vpa_checker.sv
// vpa_port_checker: port-level assertions for variable_partition_allocator
// depends on vpa_pkg

module vpa_port_checker
    import vpa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic [39:0] m_tdata
);
    // only one request in flight
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    // accepted request leads away from idle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("idle after request");
    // failed result has zero payload
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed result with payload");
    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped");
endmodule

bind variable_partition_allocator vpa_port_checker u_vpa_port_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
);

FILE: tb/vpa_checker.sv
// vpa_checker: watches the request and result channels of the allocator,
// predicts each result from its own copy of the hole and held tables; uses vpa_pkg

module vpa_checker
    import vpa_pkg::*;
#(
    parameter int HOLE_SLOTS = 16,
    parameter int HELD_SLOTS = 16,
    parameter int MEM_SIZE   = 32768,
    parameter int BASE_ADDR  = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,
    input  logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state
    logic [1:0]  policy;
    logic [15:0] split_limit;
    logic [15:0] hole_base [HOLE_SLOTS];
    logic [15:0] hole_len [HOLE_SLOTS];
    logic        hole_used [HOLE_SLOTS];
    logic [7:0]  blk_id [HELD_SLOTS];
    logic [15:0] blk_base [HELD_SLOTS];
    logic [15:0] blk_len [HELD_SLOTS];
    logic        blk_used [HELD_SLOTS];

    result_t expected_results[$];

    function automatic result_t make_result(logic [1:0] st, logic [7:0] id,
                                            logic [15:0] addr, logic [15:0] len);
        result_t r;
        r.status = st;
        r.granted_id = id;
        r.granted_addr = addr;
        r.granted_len = len;
        return r;
    endfunction

    // true if hole c beats current pick p under the fit policy
    function automatic bit hole_wins(int c, int p);
        if (policy == POLICY_WORST && hole_len[c] != hole_len[p])
            return hole_len[c] > hole_len[p];
        if (policy == POLICY_BEST && hole_len[c] != hole_len[p])
            return hole_len[c] < hole_len[p];
        return hole_base[c] < hole_base[p];
    endfunction

    function automatic result_t predict_alloc(logic [15:0] size);
        int pick;
        int slot;
        int top;
        bit found;
        bit slot_ok;
        logic [15:0] rem;
        logic [15:0] addr;
        logic [15:0] len;
        pick = 0; slot = 0; top = 0; found = 0; slot_ok = 0;
        for (int i = 0; i < HOLE_SLOTS; i++) begin
            if (!hole_used[i] || hole_len[i] <= size) continue;
            if (!found || hole_wins(i, pick)) begin
                pick = i;
                found = 1;
            end
        end
        if (!found) return make_result(ST_NOSPACE, '0, '0, '0);
        for (int i = 0; i < HELD_SLOTS; i++) begin
            if (blk_used[i]) begin
                if (blk_id[i] > top) top = blk_id[i];
            end else if (!slot_ok) begin
                slot = i;
                slot_ok = 1;
            end
        end
        if (!slot_ok || top >= 255) return make_result(ST_FULL, '0, '0, '0);
        rem = hole_len[pick] - size;
        addr = hole_base[pick];
        if (rem < split_limit) begin
            len = hole_len[pick];
            hole_used[pick] = 0;
            hole_base[pick] = 0;
            hole_len[pick] = 0;
        end else begin
            len = size;
            hole_base[pick] = addr + size;
            hole_len[pick] = rem;
        end
        blk_used[slot] = 1;
        blk_id[slot] = 8'(top + 1);
        blk_base[slot] = addr;
        blk_len[slot] = len;
        return make_result(ST_OK, 8'(top + 1), addr, len);
    endfunction

    function automatic result_t predict_free(logic [7:0] id);
        int k;
        int prev;
        int next;
        int spare;
        bit hit;
        bit has_prev;
        bit has_next;
        bit spare_ok;
        logic [15:0] s;
        logic [15:0] l;
        logic [16:0] e;
        k = 0; prev = 0; next = 0; spare = 0;
        hit = 0; has_prev = 0; has_next = 0; spare_ok = 0;
        for (int i = 0; i < HELD_SLOTS; i++) begin
            if (blk_used[i] && blk_id[i] == id && id != 0) begin
                k = i;
                hit = 1;
                break;
            end
        end
        if (!hit) return make_result(ST_BADID, '0, '0, '0);
        s = blk_base[k];
        l = blk_len[k];
        e = 17'(s) + 17'(l);
        for (int i = 0; i < HOLE_SLOTS; i++) begin
            if (!hole_used[i]) begin
                if (!spare_ok) begin
                    spare = i;
                    spare_ok = 1;
                end
                continue;
            end
            if (!has_prev && 17'(hole_base[i]) + 17'(hole_len[i]) == 17'(s)) begin
                prev = i;
                has_prev = 1;
            end else if (!has_next && 17'(hole_base[i]) == e) begin
                next = i;
                has_next = 1;
            end
        end
        if (has_prev) begin
            hole_len[prev] = hole_len[prev] + l;
            if (has_next) begin
                hole_len[prev] = hole_len[prev] + hole_len[next];
                hole_used[next] = 0;
                hole_base[next] = 0;
                hole_len[next] = 0;
            end
        end else if (has_next) begin
            hole_base[next] = s;
            hole_len[next] = hole_len[next] + l;
        end else if (spare_ok) begin
            hole_used[spare] = 1;
            hole_base[spare] = s;
            hole_len[spare] = l;
        end else begin
            return make_result(ST_FULL, '0, '0, '0);
        end
        blk_used[k] = 0;
        blk_id[k] = 0;
        blk_base[k] = 0;
        blk_len[k] = 0;
        return make_result(ST_OK, id, s, l);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = expected_results.size();

    // track config, accepted requests and results
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            policy <= FIT_POLICY_RESET;
            split_limit <= MIN_SPLIT_RESET;
            for (int i = 0; i < HOLE_SLOTS; i++) begin
                hole_used[i] = (i == 0);
                hole_base[i] = (i == 0) ? 16'(BASE_ADDR) : 16'd0;
                hole_len[i] = (i == 0) ? 16'(MEM_SIZE) : 16'd0;
            end
            for (int i = 0; i < HELD_SLOTS; i++) begin
                blk_used[i] = 0;
                blk_id[i] = 0;
                blk_base[i] = 0;
                blk_len[i] = 0;
            end
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_FIT_POLICY) policy <= cfg_wdata[1:0];
                else if (cfg_idx == CFG_MIN_SPLIT) split_limit <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_ALLOC)
                    expected_results.push_back(predict_alloc(s_tdata[15:0]));
                else
                    expected_results.push_back(predict_free(s_tdata[23:16]));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser};
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("mismatch %0t: result with no request pending", $realtime);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.granted_id != want.granted_id)
                        report_mismatch("granted_id", got.granted_id, want.granted_id);
                    if (got.granted_addr != want.granted_addr)
                        report_mismatch("granted_addr", got.granted_addr, want.granted_addr);
                    if (got.granted_len != want.granted_len)
                        report_mismatch("granted_len", got.granted_len, want.granted_len);
                end
            end
        end
    end

    initial begin
        errors = 0;
        results_seen = 0;
    end

endmodule

FILE: tb/testbench.sv
// testbench: stimulus and verdict for variable_partition_allocator
// depends on vpa_pkg, vpa_checker and the allocator RTL

module testbench;
    import vpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 60;
    localparam longint LIMIT = 3000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic        s_tuser = 0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [1:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_wdata = '0;

    int errors;
    int pending;
    int results_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int hold_cycles = 0;
    int requests_sent = 0;
    longint cycle_count = 0;

    always #1 aclk = ~aclk;

    variable_partition_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    vpa_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    // result side stalls; long hold-off counted here
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else if (hold_off) begin
            hold_cycles <= 400;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // one request: random gap, then hold valid until accepted
    task automatic send_request(logic kind, logic [15:0] size, logic [7:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {id, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    // sizes mostly small so the tables fill and fragment
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(300));
        if (r < 90) return 16'($urandom_range(4000));
        if (r < 95) return 16'($urandom);
        return 16'($urandom_range(32768));
    endfunction

    task automatic random_phase(int count);
        logic [7:0] id;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                send_request(REQ_ALLOC, pick_size(), 8'($urandom));
            end else if (r < 90) begin
                // free an id that is probably live
                id = 8'($urandom_range(20));
                send_request(REQ_FREE, 16'($urandom), id);
            end else begin
                send_request(REQ_FREE, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] policies [4];
        logic [15:0] splits [5];
        policies = '{POLICY_WORST, POLICY_BEST, POLICY_FIRST, 16'd3};
        splits = '{16'd0, 16'd16, 16'd1, 16'd500, 16'hFFFF};

        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, zero size, extremes, bad ids, whole memory
        send_request(REQ_FREE, 16'd0, 8'd0);
        send_request(REQ_FREE, 16'hFFFF, 8'd255);
        send_request(REQ_ALLOC, 16'd32768, 8'hFF);
        send_request(REQ_ALLOC, 16'hFFFF, 8'd0);
        send_request(REQ_ALLOC, 16'd0, 8'd0);
        send_request(REQ_ALLOC, 16'd100, 8'd0);
        send_request(REQ_ALLOC, 16'd200, 8'd0);
        send_request(REQ_ALLOC, 16'd50, 8'd0);
        send_request(REQ_FREE, 16'd0, 8'd2);
        send_request(REQ_FREE, 16'd0, 8'd2);
        send_request(REQ_FREE, 16'd0, 8'd3);
        send_request(REQ_FREE, 16'd0, 8'd4);
        send_request(REQ_FREE, 16'd0, 8'd1);
        // fill the held table to its limit
        for (int i = 0; i < 17; i++) send_request(REQ_ALLOC, 16'd10, 8'd0);
        for (int i = 1; i <= 16; i += 2) send_request(REQ_FREE, 16'd0, 8'(i));
        drain();
        for (int i = 0; i <= 17; i++) send_request(REQ_FREE, 16'd0, 8'(i));
        drain();

        // random phases over settings and idling mixes
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_FIT_POLICY, policies[p % 4]);
            write_reg(CFG_MIN_SPLIT, splits[p % 5]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (p == 4) begin
                hold_off <= 1;
                @(posedge aclk);
                hold_off <= 0;
            end
            random_phase(100);
            drain();
        end
        write_reg(CFG_MIN_SPLIT, 16'd32768);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(40);
        drain();

        $display("covered %0d requests, %0d results, all fit policies and split limits",
                 requests_sent, results_seen);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
